/* sv/mips_subset_instruction_execute_macros.svh */
// ----------------------------------------------------------------------------
// MIPS subset execute assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTE_MACROS_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTE_MACROS_SVH

// Same-cycle implication.
`define MIPS_EXE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MIPS_EXE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mips_exe_pkg.sv */
// ----------------------------------------------------------------------------
// MIPS subset execute package
// Opcode and function codes, register file geometry and the execute result.
// ----------------------------------------------------------------------------
package mips_exe_pkg;

  localparam int RF_DEPTH = 32;
  localparam int RF_IDX_W = 5;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_SLT = 6'd42;

  typedef struct packed {
    logic [31:0]         next_pc;
    logic                unknown;
    logic                reg_we;
    logic [RF_IDX_W-1:0] reg_idx;
    logic [31:0]         reg_val;
    logic                is_load;
    logic                mem_we;
    logic [31:0]         mem_addr;
    logic [31:0]         mem_data;
  } ex_result_t;

endpackage

/* sv/mips_exe_regfile.sv */
// ----------------------------------------------------------------------------
// MIPS subset register file
// 32 x 32 general registers, two registered read ports with write bypass.
// ----------------------------------------------------------------------------
module mips_exe_regfile
  import mips_exe_pkg::*;
(
  input  logic                clk,
  input  logic                rd_en,
  input  logic [RF_IDX_W-1:0] rd_idx_a,
  input  logic [RF_IDX_W-1:0] rd_idx_b,
  output logic [31:0]         rd_data_a,
  output logic [31:0]         rd_data_b,
  input  logic                wr_en,
  input  logic [RF_IDX_W-1:0] wr_idx,
  input  logic [31:0]         wr_data
);

  logic [31:0] mem [RF_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= (wr_en && wr_idx == rd_idx_a) ? wr_data : mem[rd_idx_a];
      rd_data_b <= (wr_en && wr_idx == rd_idx_b) ? wr_data : mem[rd_idx_b];
    end
  end

endmodule

/* sv/mips_exe_dmem.sv */
// ----------------------------------------------------------------------------
// MIPS subset data store
// Word memory with separate read and write ports and registered read data.
// ----------------------------------------------------------------------------
module mips_exe_dmem
  import mips_exe_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [31:0]      rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [31:0]      wr_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

/* sv/mips_exe_alu.sv */
// ----------------------------------------------------------------------------
// MIPS subset execute unit
// Decodes one instruction and computes next pc, register and memory effects.
// ----------------------------------------------------------------------------
module mips_exe_alu
  import mips_exe_pkg::*;
(
  input  logic [31:0] instr,
  input  logic [31:0] pc,
  input  logic [31:0] opa,
  input  logic [31:0] opb,
  output ex_result_t  res
);

  logic [5:0]          op;
  logic [5:0]          fn;
  logic [RF_IDX_W-1:0] rt;
  logic [RF_IDX_W-1:0] rd;
  logic [31:0]         uimm;
  logic [31:0]         simm;
  logic [31:0]         pc4;
  logic [31:0]         br_pc;
  logic [31:0]         ea;
  ex_result_t          r;

  assign op    = instr[31:26];
  assign fn    = instr[5:0];
  assign rt    = instr[20:16];
  assign rd    = instr[15:11];
  assign uimm  = {16'd0, instr[15:0]};
  assign simm  = {{16{instr[15]}}, instr[15:0]};
  assign pc4   = pc + 32'd4;
  assign br_pc = pc4 + {simm[29:0], 2'b00};
  assign ea    = opa + simm;

  always_comb begin
    r          = '0;
    r.next_pc  = pc4;
    if (instr != 32'd0) begin
      case (op)
        OP_RTYPE: begin
          r.reg_we  = 1'b1;
          r.reg_idx = rd;
          case (fn)
            FN_ADD:  r.reg_val = opa + opb;
            FN_SUB:  r.reg_val = opa - opb;
            FN_AND:  r.reg_val = opa & opb;
            FN_OR:   r.reg_val = opa | opb;
            FN_SLT:  r.reg_val = {31'd0, $signed(opa) < $signed(opb)};
            default: begin
              r.reg_we  = 1'b0;
              r.unknown = 1'b1;
            end
          endcase
        end
        OP_ADDI: begin
          r.reg_we  = 1'b1;
          r.reg_idx = rt;
          r.reg_val = ea;
        end
        OP_ANDI: begin
          r.reg_we  = 1'b1;
          r.reg_idx = rt;
          r.reg_val = opa & uimm;
        end
        OP_ORI: begin
          r.reg_we  = 1'b1;
          r.reg_idx = rt;
          r.reg_val = opa | uimm;
        end
        OP_SLTI: begin
          r.reg_we  = 1'b1;
          r.reg_idx = rt;
          r.reg_val = {31'd0, $signed(opa) < $signed(simm)};
        end
        OP_LUI: begin
          r.reg_we  = 1'b1;
          r.reg_idx = rt;
          r.reg_val = {instr[15:0], 16'd0};
        end
        OP_LW: begin
          r.reg_we   = 1'b1;
          r.reg_idx  = rt;
          r.is_load  = 1'b1;
          r.mem_addr = ea;
        end
        OP_SW: begin
          r.mem_we   = 1'b1;
          r.mem_addr = ea;
          r.mem_data = opb;
        end
        OP_BEQ: begin
          if (opa == opb) begin
            r.next_pc = br_pc;
          end
        end
        OP_BNE: begin
          if (opa != opb) begin
            r.next_pc = br_pc;
          end
        end
        OP_J: begin
          r.next_pc = {4'd0, instr[25:0], 2'b00};
        end
        default: begin
          r.unknown = 1'b1;
        end
      endcase
    end
    // drop writes aimed at register zero
    if (!r.reg_we || r.reg_idx == '0) begin
      r.reg_we  = 1'b0;
      r.reg_idx = '0;
      r.reg_val = '0;
      r.is_load = 1'b0;
    end
    res = r;
  end

endmodule

/* sv/mips_subset_instruction_execute.sv */
// ----------------------------------------------------------------------------
// MIPS subset instruction execute
// Executes one fetched instruction word against pc, registers and data store.
// ----------------------------------------------------------------------------
// One instruction is accepted per clock while the output is not stalled. The
// register file is read at the accept edge into its read registers, the
// execute unit works from the instruction register, and the data store access
// and the load of the result into the output register happen when execute
// advances. Results of the instruction just ahead are forwarded into execute,
// so dependent instructions, loads included, issue back to back. After reset a
// clearing pass zeroes the data store and the register file; no item is
// accepted during that pass. The user must keep DATA_WORDS a power of two; the
// block does not enforce it. The word index is taken from address bits above the byte offset.
`include "mips_subset_instruction_execute_macros.svh"

module mips_subset_instruction_execute
  import mips_exe_pkg::*;
#(
  parameter int DATA_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_pc,
  output logic        out_unknown_instruction,
  output logic        out_reg_write_enable,
  output logic [4:0]  out_reg_write_index,
  output logic signed [31:0] out_reg_write_value,
  output logic        out_mem_write_enable,
  output logic [31:0] out_mem_address,
  output logic signed [31:0] out_mem_write_data
);

  localparam int IDX_W = $clog2(DATA_WORDS);
  localparam int CLR_N = (DATA_WORDS > RF_DEPTH) ? DATA_WORDS : RF_DEPTH;
  localparam int CLR_W = $clog2(CLR_N);

  logic                clr_r;
  logic [CLR_W-1:0]    clr_cnt_r;
  logic                ex_valid_r;
  logic [31:0]         ir_r;
  logic [31:0]         pc_r;
  logic                out_valid_r;
  logic [31:0]         next_pc_r;
  logic                unknown_r;
  logic                wb_we_r;
  logic [RF_IDX_W-1:0] wb_idx_r;
  logic [31:0]         wb_alu_r;
  logic                wb_load_r;
  logic                wb_pend_r;
  logic                mem_we_r;
  logic [31:0]         mem_addr_r;
  logic [31:0]         mem_data_r;

  logic                acc;
  logic                ex_adv;
  logic [31:0]         rs_q;
  logic [31:0]         rt_q;
  logic [31:0]         ld_data;
  logic [31:0]         wb_val;
  logic [31:0]         opa;
  logic [31:0]         opb;
  ex_result_t          ex_res;
  logic                rf_we;
  logic [RF_IDX_W-1:0] rf_widx;
  logic [31:0]         rf_wdata;
  logic                dm_we;
  logic [IDX_W-1:0]    dm_idx;
  logic [31:0]         dm_wdata;

  assign ex_adv   = ex_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_r && (!ex_valid_r || ex_adv);
  assign acc      = in_valid && in_ready;

  assign wb_val = wb_load_r ? ld_data : wb_alu_r;
  assign opa = (wb_we_r && wb_idx_r == ir_r[25:21]) ? wb_val : rs_q;
  assign opb = (wb_we_r && wb_idx_r == ir_r[20:16]) ? wb_val : rt_q;

  assign rf_we    = clr_r ? ({1'b0, clr_cnt_r} < (CLR_W + 1)'(RF_DEPTH))
                          : (wb_pend_r && wb_we_r);
  assign rf_widx  = clr_r ? clr_cnt_r[RF_IDX_W-1:0] : wb_idx_r;
  assign rf_wdata = clr_r ? 32'd0 : wb_val;

  assign dm_we    = clr_r ? ({1'b0, clr_cnt_r} < (CLR_W + 1)'(DATA_WORDS))
                          : (ex_adv && ex_res.mem_we);
  assign dm_idx   = clr_r ? clr_cnt_r[IDX_W-1:0] : ex_res.mem_addr[IDX_W+1:2];
  assign dm_wdata = clr_r ? 32'd0 : ex_res.mem_data;

  mips_exe_regfile u_regfile (
    .clk       (clk),
    .rd_en     (acc),
    .rd_idx_a  (in_instruction[25:21]),
    .rd_idx_b  (in_instruction[20:16]),
    .rd_data_a (rs_q),
    .rd_data_b (rt_q),
    .wr_en     (rf_we),
    .wr_idx    (rf_widx),
    .wr_data   (rf_wdata)
  );

  mips_exe_alu u_alu (
    .instr (ir_r),
    .pc    (pc_r),
    .opa   (opa),
    .opb   (opb),
    .res   (ex_res)
  );

  mips_exe_dmem #(
    .DEPTH (DATA_WORDS),
    .IDX_W (IDX_W)
  ) u_dmem (
    .clk     (clk),
    .rd_en   (ex_adv),
    .rd_idx  (dm_idx),
    .rd_data (ld_data),
    .wr_en   (dm_we),
    .wr_idx  (dm_idx),
    .wr_data (dm_wdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      ex_valid_r  <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      wb_we_r     <= 1'b0;
      wb_load_r   <= 1'b0;
      wb_pend_r   <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(CLR_N - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (acc) begin
        ex_valid_r <= 1'b1;
      end else if (ex_adv) begin
        ex_valid_r <= 1'b0;
      end
      if (ex_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      wb_pend_r <= ex_adv && ex_res.reg_we;
      if (ex_adv) begin
        pc_r      <= ex_res.next_pc;
        wb_we_r   <= ex_res.reg_we;
        wb_load_r <= ex_res.is_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ir_r <= in_instruction;
    end
    if (ex_adv) begin
      next_pc_r  <= ex_res.next_pc;
      unknown_r  <= ex_res.unknown;
      wb_idx_r   <= ex_res.reg_idx;
      wb_alu_r   <= ex_res.reg_val;
      mem_we_r   <= ex_res.mem_we;
      mem_addr_r <= ex_res.mem_addr;
      mem_data_r <= ex_res.mem_data;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_next_pc             = next_pc_r;
  assign out_unknown_instruction = unknown_r;
  assign out_reg_write_enable    = wb_we_r;
  assign out_reg_write_index     = wb_idx_r;
  assign out_reg_write_value     = wb_val;
  assign out_mem_write_enable    = mem_we_r;
  assign out_mem_address         = mem_addr_r;
  assign out_mem_write_data      = mem_data_r;

  `MIPS_EXE_ASSERT_IMP(a_no_accept_in_clear, clr_r, !in_ready, "item accepted during clear")
  `MIPS_EXE_ASSERT_IMP(a_wb_not_r0, wb_pend_r, wb_we_r && wb_idx_r != '0, "bad register write")
  `MIPS_EXE_ASSERT_NXT(a_adv_fills_out, ex_adv, out_valid_r, "result register not loaded")
  `MIPS_EXE_ASSERT_NXT(a_pc_tracks_out, ex_adv, pc_r == next_pc_r, "pc and result disagree")

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// MIPS subset execute testbench
// Feeds instruction words through the valid/ready input, runs a local
// architectural copy of pc, registers and data store, and checks every field
// of each retired result against it. The sender runs in bursts and gaps, the
// receiver stalls on its own pattern, with long receive hold-offs and
// full drains between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import mips_exe_pkg::*;

  localparam int DMEM_WORDS  = 1024;
  localparam int NUM_RANDOM  = 930;
  localparam int DRAIN_AT    = 500;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT  = 6000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        unknown;
    logic        reg_we;
    logic [4:0]  reg_idx;
    logic [31:0] reg_val;
    logic        mem_we;
    logic [31:0] mem_addr;
    logic [31:0] mem_data;
  } exec_result_t;

  typedef struct {
    bit          drain;
    logic [31:0] word;
  } fetch_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_instruction = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_next_pc;
  logic        out_unknown_instruction;
  logic        out_reg_write_enable;
  logic [4:0]  out_reg_write_index;
  logic signed [31:0] out_reg_write_value;
  logic        out_mem_write_enable;
  logic [31:0] out_mem_address;
  logic signed [31:0] out_mem_write_data;

  logic [31:0] pc_model;
  logic [31:0] gpr [RF_DEPTH];
  logic [31:0] dmem [DMEM_WORDS];

  fetch_item_t  fetch_q [$];
  exec_result_t retire_q [$];

  int n_accepted = 0;
  int n_retired  = 0;
  int n_fail     = 0;
  int gap_left   = 0;
  int burst_left = 0;
  int hold_left  = 0;
  int hold_count = 0;
  int rx_cyc     = 0;
  int idle_cycles = 0;

  mips_subset_instruction_execute #(
    .DATA_WORDS(DMEM_WORDS)
  ) u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_instruction          (in_instruction),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_next_pc             (out_next_pc),
    .out_unknown_instruction (out_unknown_instruction),
    .out_reg_write_enable    (out_reg_write_enable),
    .out_reg_write_index     (out_reg_write_index),
    .out_reg_write_value     (out_reg_write_value),
    .out_mem_write_enable    (out_mem_write_enable),
    .out_mem_address         (out_mem_address),
    .out_mem_write_data      (out_mem_write_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic exec_result_t execute_instr(input logic [31:0] ins);
    exec_result_t r;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [31:0] uimm;
    logic [31:0] simm;
    logic [31:0] a;
    logic [31:0] b;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    op   = ins[31:26];
    rs   = ins[25:21];
    rt   = ins[20:16];
    rd   = ins[15:11];
    fn   = ins[5:0];
    uimm = {16'h0000, ins[15:0]};
    simm = {{16{ins[15]}}, ins[15:0]};
    a    = gpr[rs];
    b    = gpr[rt];
    wr   = 1'b0;
    widx = '0;
    wval = '0;
    r    = '0;
    r.next_pc = pc_model + 32'd4;
    if (ins != 32'h0) begin
      case (op)
        OP_RTYPE: begin
          wr   = 1'b1;
          widx = rd;
          case (fn)
            FN_ADD:  wval = a + b;
            FN_SUB:  wval = a - b;
            FN_AND:  wval = a & b;
            FN_OR:   wval = a | b;
            FN_SLT:  wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            default: begin
              wr = 1'b0;
              r.unknown = 1'b1;
            end
          endcase
        end
        OP_ADDI: begin
          wr = 1'b1; widx = rt; wval = a + simm;
        end
        OP_ANDI: begin
          wr = 1'b1; widx = rt; wval = a & uimm;
        end
        OP_ORI: begin
          wr = 1'b1; widx = rt; wval = a | uimm;
        end
        OP_SLTI: begin
          wr = 1'b1; widx = rt;
          wval = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
        end
        OP_LUI: begin
          wr = 1'b1; widx = rt; wval = {ins[15:0], 16'h0000};
        end
        OP_LW: begin
          r.mem_addr = a + simm;
          wr = 1'b1; widx = rt;
          wval = dmem[(r.mem_addr >> 2) % DMEM_WORDS];
        end
        OP_SW: begin
          r.mem_addr = a + simm;
          r.mem_we   = 1'b1;
          r.mem_data = b;
          dmem[(r.mem_addr >> 2) % DMEM_WORDS] = b;
        end
        OP_BEQ: if (a == b) r.next_pc = r.next_pc + (simm << 2);
        OP_BNE: if (a != b) r.next_pc = r.next_pc + (simm << 2);
        OP_J:   r.next_pc = {4'h0, ins[25:0], 2'b00};
        default: r.unknown = 1'b1;
      endcase
    end
    if (wr && widx != 5'd0) begin
      r.reg_we  = 1'b1;
      r.reg_idx = widx;
      r.reg_val = wval;
      gpr[widx] = wval;
    end
    pc_model = r.next_pc;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rd,
                                        input logic [4:0] rs, input logic [4:0] rt);
    logic [4:0] shamt;
    shamt = 5'($urandom_range(0, 31));
    return {OP_RTYPE, rs, rt, rd, shamt, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rt,
                                        input logic [4:0] rs, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] pick_offset();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63) * 4);
  endfunction

  task automatic push_word(input logic [31:0] w);
    fetch_item_t it;
    it.drain = 1'b0;
    it.word  = w;
    fetch_q.push_back(it);
  endtask

  task automatic push_drain();
    fetch_item_t it;
    it.drain = 1'b1;
    it.word  = '0;
    fetch_q.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    logic        nxt_valid;
    logic [31:0] nxt_word;
    fetch_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_word  = in_instruction;
      if (in_valid && in_ready) begin
        retire_q.push_back(execute_instr(in_instruction));
        n_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (fetch_q.size() > 0) begin
          if (fetch_q[0].drain) begin
            if (n_accepted == n_retired) void'(fetch_q.pop_front());
          end else begin
            it        = fetch_q.pop_front();
            nxt_word  = it.word;
            nxt_valid = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 80 : 12);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
          end
        end
      end
      in_valid       <= nxt_valid;
      in_instruction <= nxt_word;
    end
  end

  // receiver stall pattern, with long hold-offs
  always @(posedge clk) begin : recv_proc
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cyc++;
      if (hold_left == 0 && hold_count < 2 && n_retired >= ((hold_count == 0) ? 150 : 700)) begin
        hold_left = HOLD_CYCLES;
        hold_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cyc / 97) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= (rx_cyc % 3 != 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_proc
    exec_result_t want;
    if (rst_n && out_valid && out_ready) begin
      n_retired <= n_retired + 1;
      if (retire_q.size() == 0) begin
        $error("result with no pending expectation");
        n_fail++;
      end else begin
        want = retire_q.pop_front();
        if (out_next_pc !== want.next_pc) begin
          $error("next_pc: expected %h, actual %h", want.next_pc, out_next_pc);
          n_fail++;
        end
        if (out_unknown_instruction !== want.unknown) begin
          $error("unknown_instruction: expected %b, actual %b", want.unknown,
                 out_unknown_instruction);
          n_fail++;
        end
        if (out_reg_write_enable !== want.reg_we) begin
          $error("reg_write_enable: expected %b, actual %b", want.reg_we, out_reg_write_enable);
          n_fail++;
        end
        if (out_reg_write_index !== want.reg_idx) begin
          $error("reg_write_index: expected %0d, actual %0d", want.reg_idx, out_reg_write_index);
          n_fail++;
        end
        if (out_reg_write_value !== want.reg_val) begin
          $error("reg_write_value: expected %h, actual %h", want.reg_val, out_reg_write_value);
          n_fail++;
        end
        if (out_mem_write_enable !== want.mem_we) begin
          $error("mem_write_enable: expected %b, actual %b", want.mem_we, out_mem_write_enable);
          n_fail++;
        end
        if (out_mem_address !== want.mem_addr) begin
          $error("mem_address: expected %h, actual %h", want.mem_addr, out_mem_address);
          n_fail++;
        end
        if (out_mem_write_data !== want.mem_data) begin
          $error("mem_write_data: expected %h, actual %h", want.mem_data, out_mem_write_data);
          n_fail++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin : watch_proc
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stim_proc
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  ra;
    logic [15:0] off;
    pc_model = '0;
    for (int i = 0; i < RF_DEPTH; i++) gpr[i] = '0;
    for (int i = 0; i < DMEM_WORDS; i++) dmem[i] = '0;

    push_word(32'h0000_0000);
    push_word(enc_i(OP_LUI, 5'd1, 5'd0, 16'hFFFF));
    push_word(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
    push_word(enc_i(OP_LUI, 5'd2, 5'd0, 16'h7FFF));
    push_word(enc_i(OP_ORI, 5'd2, 5'd2, 16'hFFFF));
    push_word(enc_r(FN_ADD, 5'd3, 5'd2, 5'd2));
    push_word(enc_r(FN_SUB, 5'd4, 5'd0, 5'd2));
    push_word(enc_r(FN_AND, 5'd5, 5'd1, 5'd2));
    push_word(enc_r(FN_OR, 5'd6, 5'd4, 5'd2));
    push_word(enc_r(FN_SLT, 5'd7, 5'd1, 5'd2));
    push_word(enc_i(OP_SLTI, 5'd8, 5'd2, 16'h8000));
    push_word(enc_i(OP_ANDI, 5'd9, 5'd1, 16'hFFFF));
    push_word(enc_i(OP_ADDI, 5'd10, 5'd0, 16'h8000));
    push_word(enc_i(OP_ADDI, 5'd0, 5'd1, 16'h0005));
    push_word(enc_i(OP_SW, 5'd1, 5'd0, 16'h7FFC));
    push_word(enc_i(OP_LW, 5'd11, 5'd0, 16'h7FFC));
    push_word(enc_i(OP_SW, 5'd2, 5'd0, 16'h0003));
    push_word(enc_i(OP_LW, 5'd12, 5'd0, 16'h1003));
    push_word(enc_i(OP_LW, 5'd13, 5'd1, 16'h8000));
    push_word(enc_i(OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
    push_word(enc_i(OP_BNE, 5'd2, 5'd1, 16'h7FFF));
    push_word(enc_i(OP_BEQ, 5'd2, 5'd1, 16'h0010));
    push_word({OP_J, 26'h3FF_FFFF});
    push_word({OP_J, 26'h000_0000});
    push_word({6'h3F, 26'h155_5555});
    push_word(enc_r(6'h3F, 5'd14, 5'd1, 5'd2));
    push_word(32'h0000_0001);
    push_drain();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == DRAIN_AT) push_drain();
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          case ($urandom_range(0, 4))
            0:       fn = FN_ADD;
            1:       fn = FN_SUB;
            2:       fn = FN_AND;
            3:       fn = FN_OR;
            default: fn = FN_SLT;
          endcase
          push_word(enc_r(fn, pick_reg(), pick_reg(), pick_reg()));
        end
        4, 5, 6: begin
          case ($urandom_range(0, 4))
            0:       op = OP_ADDI;
            1:       op = OP_ANDI;
            2:       op = OP_ORI;
            3:       op = OP_SLTI;
            default: op = OP_LUI;
          endcase
          push_word(enc_i(op, pick_reg(), pick_reg(), 16'($urandom)));
        end
        7, 8: begin
          ra  = ($urandom_range(0, 1) == 0) ? 5'd0 : pick_reg();
          off = pick_offset();
          push_word(enc_i(OP_SW, pick_reg(), ra, off));
          push_word(enc_i(OP_LW, pick_reg(), ra, off));
        end
        9, 10: begin
          ra = ($urandom_range(0, 1) == 0) ? 5'd0 : pick_reg();
          push_word(enc_i(OP_LW, pick_reg(), ra, pick_offset()));
        end
        11, 12: begin
          ra = ($urandom_range(0, 1) == 0) ? 5'd0 : pick_reg();
          push_word(enc_i(OP_SW, pick_reg(), ra, pick_offset()));
        end
        13, 14: begin
          op = ($urandom_range(0, 1) == 0) ? OP_BEQ : OP_BNE;
          ra = pick_reg();
          push_word(enc_i(op, ($urandom_range(0, 1) == 0) ? ra : pick_reg(), ra,
                          16'($urandom)));
        end
        15: push_word({OP_J, 26'($urandom)});
        16: push_word(($urandom_range(0, 1) == 0) ? 32'h0 : 32'($urandom));
        17: begin
          do op = 6'($urandom_range(1, 63));
          while (op inside {OP_J, OP_BEQ, OP_BNE, OP_ADDI, OP_SLTI, OP_ANDI, OP_ORI,
                            OP_LUI, OP_LW, OP_SW});
          push_word({op, 26'($urandom)});
        end
        18: begin
          do fn = 6'($urandom_range(1, 63));
          while (fn inside {FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT});
          push_word(enc_r(fn, pick_reg(), pick_reg(), pick_reg()));
        end
        default: push_word(enc_i(OP_ADDI, pick_reg(), pick_reg(), 16'($urandom_range(0, 255))));
      endcase
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (fetch_q.size() != 0 || in_valid || retire_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (retire_q.size() != 0) begin
      $error("%0d expected results never arrived", retire_q.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
